// ===== sv/frlm_pkg.sv =====
// shared constants and codes for the frame rate and latency monitor
`default_nettype none
package frlm_pkg;
   localparam int TimeWidth     = 48;
   localparam int IdWidth       = 32;
   localparam int FrameWidth    = 24;
   localparam int FpsWidth      = 32;
   localparam int LiveWidth     = 5;
   localparam int DefaultSlots  = 16;
   localparam int DivStepWidth  = 6;
   localparam logic [31:0] IntervalReset = 32'd1000000;
   localparam logic [16:0] FpsScale      = 17'd100000;
   localparam logic [TimeWidth-1:0] UsPerMs = 48'd1000;
   // ceil(2^36 / 1000), exact quotient for 26-bit dividends
   localparam logic [26:0] MsRecip      = 27'd68719477;
   localparam int          MsRecipShift = 36;
   localparam logic [TimeWidth-1:0] TimeMax = {TimeWidth{1'b1}};
   localparam logic [FrameWidth-1:0] FrameMax = {FrameWidth{1'b1}};
   localparam logic [FpsWidth-1:0] FpsMax = {FpsWidth{1'b1}};
   localparam logic [LiveWidth-1:0] LiveMax = {LiveWidth{1'b1}};
   localparam logic FuncBegin = 1'b0;
   localparam logic FuncEnd   = 1'b1;
   typedef logic [TimeWidth-1:0] time_type;
endpackage
`default_nettype wire

// ===== sv/frame_rate_latency_monitor.sv =====
// frame rate and latency monitor, top level
// a begin event takes a slot memory scan; an end event without report takes the scan and a slot update
// an end event with report adds a six-step ms conversion, up to 3 divides and a purge scan of the slots
// one item at a time, set by the slot memory scans and the one-bit-per-cycle divider
// synchronous active-high reset clears sums, slot valid bits and control, interval 1000000
`default_nettype none
module frame_rate_latency_monitor import frlm_pkg::*; #(
   parameter int BUFFER_SLOTS = DefaultSlots
) (
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   req_valid,
   output logic                  req_stall,
   input  wire                   req_func,
   input  wire  [IdWidth-1:0]    req_buffer_id,
   input  wire  [TimeWidth-1:0]  req_timestamp_us,
   output logic                  rsp_valid,
   input  wire                   rsp_stall,
   output logic [FpsWidth-1:0]   rsp_fps_x100,
   output logic [TimeWidth-1:0]  rsp_render_avg_us,
   output logic [TimeWidth-1:0]  rsp_queue_lag_avg_us,
   output logic [LiveWidth-1:0]  rsp_live_buffers,
   input  wire                   csr_valid,
   output logic                  csr_ready,
   input  wire  [31:0]           csr_report_interval_us
);
   localparam int IdxW = $clog2(BUFFER_SLOTS);
   localparam int CntW = $clog2(BUFFER_SLOTS + 1);

   // sequencer codes
   localparam logic [2:0] S_IDLE = 3'd0, S_SCAN = 3'd1, S_UPD = 3'd2, S_DSTART = 3'd3,
                          S_DWAIT = 3'd4, S_PURGE = 3'd5, S_OUT = 3'd6, S_MS = 3'd7;
   localparam logic [1:0] D_FPS = 2'd1, D_REN = 2'd2, D_LAT = 2'd3;
   localparam logic [2:0] MsLastStep = 3'd5;

   // slot memory: buffer id and last end time per entry
   logic [IdWidth+TimeWidth-1:0] slot_mem [BUFFER_SLOTS];
   logic [IdWidth+TimeWidth-1:0] rd_data_ff;
   logic [IdxW-1:0]              rd_addr;
   logic [IdWidth-1:0]           rd_id;
   time_type                     rd_end;
   logic [BUFFER_SLOTS-1:0]      slot_valid_ff;

   logic [2:0]          state_ff;
   logic [1:0]          step_ff;
   logic [CntW-1:0]     cnt_ff;
   logic [IdxW-1:0]     proc_idx;
   logic                func_ff;
   logic [IdWidth-1:0]  id_ff;
   time_type            now_ff;
   logic [31:0]         interval_cfg_ff;

   // scan results
   logic                match_ff, free_ff, min_ff;
   logic [IdxW-1:0]     match_idx_ff, free_idx_ff, min_idx_ff;
   time_type            match_end_ff, min_end_ff;

   time_type            begin_time_ff, render_sum_ff, latency_sum_ff, last_report_ff;
   logic [FrameWidth-1:0] frames_ff, frames_in;
   time_type            span_ff, ms_ff;
   logic [40:0]         prod_ff;
   logic [FpsWidth-1:0] fps_ff;
   time_type            ren_ff, lat_ff;
   logic [LiveWidth-1:0] live_ff;
   logic [IdxW-1:0]     wr_idx;

   // span to milliseconds, 16-bit digit long division by reciprocal
   logic [2:0]          ms_step_ff;
   logic [9:0]          ms_rem_ff;
   logic [15:0]         ms_q_ff, ms_digit, ms_qd;
   logic [25:0]         ms_val, ms_back;
   logic [52:0]         ms_prod;

   logic                div_start, div_done;
   time_type            div_num, div_den, div_quo;
   logic [TimeWidth:0]  lag_sum, ren_sum;
   time_type            span_now, age;

   logic accept_req, out_load;

   assign accept_req = req_valid && !req_stall;
   assign req_stall  = (state_ff != S_IDLE);
   assign csr_ready  = 1'b1;
   assign out_load   = (state_ff == S_OUT) && (!rsp_valid || !rsp_stall);

   assign proc_idx = IdxW'(cnt_ff - 1'b1);
   assign rd_addr  = cnt_ff[IdxW-1:0];
   assign rd_id    = rd_data_ff[IdWidth+TimeWidth-1:TimeWidth];
   assign rd_end   = rd_data_ff[TimeWidth-1:0];
   assign wr_idx   = match_ff ? match_idx_ff : (free_ff ? free_idx_ff : min_idx_ff);

   assign lag_sum  = {1'b0, latency_sum_ff} + {1'b0, time_type'(now_ff - match_end_ff)};
   assign ren_sum  = {1'b0, render_sum_ff} + {1'b0, time_type'(now_ff - begin_time_ff)};
   assign frames_in = (frames_ff == FrameMax) ? frames_ff : frames_ff + 1'b1;
   assign span_now = now_ff - last_report_ff;
   assign age      = now_ff - rd_end;

   // digit of the span taken at each pair of ms steps, most significant first
   always_comb begin
      case (ms_step_ff[2:1])
         2'd0:    ms_digit = span_ff[TimeWidth-1:TimeWidth-16];
         2'd1:    ms_digit = span_ff[TimeWidth-17:TimeWidth-32];
         default: ms_digit = span_ff[TimeWidth-33:0];
      endcase
   end
   assign ms_val  = {ms_rem_ff, ms_digit};
   assign ms_prod = ms_val * MsRecip;
   assign ms_qd   = 16'(ms_prod >> MsRecipShift);
   assign ms_back = {10'd0, ms_q_ff} * UsPerMs[25:0];

   // operand select for the shared divider
   always_comb begin
      div_num = TimeWidth'(prod_ff);
      div_den = ms_ff;
      case (step_ff)
         D_FPS: begin
            div_num = TimeWidth'(prod_ff);
            div_den = ms_ff;
         end
         D_REN: begin
            div_num = render_sum_ff;
            div_den = TimeWidth'(frames_ff);
         end
         D_LAT: begin
            div_num = latency_sum_ff;
            div_den = TimeWidth'(frames_ff);
         end
         default: begin
            div_num = TimeWidth'(prod_ff);
            div_den = ms_ff;
         end
      endcase
   end
   assign div_start = (state_ff == S_DSTART);

   frlm_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_num),
      .divisor  (div_den),
      .done     (div_done),
      .quotient (div_quo)
   );

   // memory read and write ports
   always_ff @(posedge clock) begin
      rd_data_ff <= slot_mem[rd_addr];
      if (state_ff == S_UPD) begin
         slot_mem[wr_idx] <= {id_ff, now_ff};
      end
   end

   // configuration register
   always_ff @(posedge clock) begin
      if (reset) begin
         interval_cfg_ff <= IntervalReset;
      end else if (csr_valid && csr_ready) begin
         interval_cfg_ff <= csr_report_interval_us;
      end
   end

   function automatic time_type sat_lag(input time_type a, input time_type b);
      logic [TimeWidth:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[TimeWidth] ? TimeMax : s[TimeWidth-1:0];
   endfunction

   // sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_IDLE;
         slot_valid_ff  <= '0;
         begin_time_ff  <= '0;
         render_sum_ff  <= '0;
         latency_sum_ff <= '0;
         frames_ff      <= '0;
         last_report_ff <= '0;
         rsp_valid      <= 1'b0;
         cnt_ff         <= '0;
         step_ff        <= D_FPS;
      end else begin
         if (out_load) begin
            rsp_valid <= 1'b1;
         end else if (rsp_valid && !rsp_stall) begin
            rsp_valid <= 1'b0;
         end
         case (state_ff)
            S_IDLE: begin
               if (accept_req) begin
                  func_ff  <= req_func;
                  id_ff    <= req_buffer_id;
                  now_ff   <= req_timestamp_us;
                  cnt_ff   <= '0;
                  match_ff <= 1'b0;
                  free_ff  <= 1'b0;
                  min_ff   <= 1'b0;
                  state_ff <= S_SCAN;
               end
            end
            S_SCAN: begin
               // read issued for cnt, data of cnt-1 examined
               cnt_ff <= cnt_ff + 1'b1;
               if (cnt_ff != '0) begin
                  if (slot_valid_ff[proc_idx]) begin
                     if (!match_ff && rd_id == id_ff) begin
                        match_ff     <= 1'b1;
                        match_idx_ff <= proc_idx;
                        match_end_ff <= rd_end;
                     end
                     if (!min_ff || rd_end < min_end_ff) begin
                        min_ff     <= 1'b1;
                        min_idx_ff <= proc_idx;
                        min_end_ff <= rd_end;
                     end
                  end else if (!free_ff) begin
                     free_ff     <= 1'b1;
                     free_idx_ff <= proc_idx;
                  end
               end
               if (cnt_ff == CntW'(BUFFER_SLOTS)) begin
                  if (func_ff == FuncBegin) begin
                     begin_time_ff <= now_ff;
                     state_ff      <= S_IDLE;
                  end else begin
                     state_ff <= S_UPD;
                  end
               end
            end
            S_UPD: begin
               slot_valid_ff[wr_idx] <= 1'b1;
               render_sum_ff <= ren_sum[TimeWidth] ? TimeMax : ren_sum[TimeWidth-1:0];
               frames_ff     <= frames_in;
               span_ff       <= span_now;
               ms_step_ff    <= '0;
               ms_rem_ff     <= '0;
               if (span_now < TimeWidth'(interval_cfg_ff)) begin
                  state_ff <= S_IDLE;
               end else begin
                  state_ff <= S_MS;
               end
            end
            S_MS: begin
               // even step: quotient digit, odd step: remainder and shift in the digit
               ms_step_ff <= ms_step_ff + 1'b1;
               if (!ms_step_ff[0]) begin
                  ms_q_ff <= ms_qd;
               end else begin
                  ms_rem_ff <= 10'(ms_val - ms_back);
                  ms_ff     <= {ms_ff[TimeWidth-17:0], ms_q_ff};
               end
               if (ms_step_ff == MsLastStep) begin
                  prod_ff  <= frames_ff * FpsScale;
                  state_ff <= S_DSTART;
                  // under one millisecond the rate saturates
                  if (span_ff < UsPerMs) begin
                     fps_ff  <= FpsMax;
                     step_ff <= D_REN;
                  end else begin
                     step_ff <= D_FPS;
                  end
               end
            end
            S_DSTART: begin
               state_ff <= S_DWAIT;
            end
            S_DWAIT: begin
               if (div_done) begin
                  state_ff <= S_DSTART;
                  case (step_ff)
                     D_FPS: begin
                        fps_ff  <= (div_quo > TimeWidth'(FpsMax)) ? FpsMax
                                                                 : div_quo[FpsWidth-1:0];
                        step_ff <= D_REN;
                     end
                     D_REN: begin
                        ren_ff  <= div_quo;
                        step_ff <= D_LAT;
                     end
                     D_LAT: begin
                        lat_ff   <= div_quo;
                        cnt_ff   <= '0;
                        live_ff  <= '0;
                        state_ff <= S_PURGE;
                     end
                     default: begin
                        step_ff <= D_FPS;
                     end
                  endcase
               end
            end
            S_PURGE: begin
               // age out entries and count the survivors
               cnt_ff <= cnt_ff + 1'b1;
               if (cnt_ff != '0 && slot_valid_ff[proc_idx]) begin
                  if (age >= TimeWidth'(interval_cfg_ff)) begin
                     slot_valid_ff[proc_idx] <= 1'b0;
                  end else if (live_ff != LiveMax) begin
                     live_ff <= live_ff + 1'b1;
                  end
               end
               if (cnt_ff == CntW'(BUFFER_SLOTS)) begin
                  state_ff <= S_OUT;
               end
            end
            S_OUT: begin
               if (out_load) begin
                  last_report_ff <= now_ff;
                  frames_ff      <= '0;
                  render_sum_ff  <= '0;
                  latency_sum_ff <= '0;
                  state_ff       <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
         // begin event with a known buffer adds its queue lag
         if (state_ff == S_SCAN && cnt_ff == CntW'(BUFFER_SLOTS) && func_ff == FuncBegin
             && (match_ff || (slot_valid_ff[proc_idx] && rd_id == id_ff))) begin
            if (match_ff) begin
               latency_sum_ff <= lag_sum[TimeWidth] ? TimeMax : lag_sum[TimeWidth-1:0];
            end else begin
               latency_sum_ff <= sat_lag(latency_sum_ff, time_type'(now_ff - rd_end));
            end
         end
      end
   end

   // result register, held until the transfer completes
   always_ff @(posedge clock) begin
      if (out_load) begin
         rsp_fps_x100         <= fps_ff;
         rsp_render_avg_us    <= ren_ff;
         rsp_queue_lag_avg_us <= lat_ff;
         rsp_live_buffers     <= live_ff;
      end
   end

   // a written slot is live in the next cycle
   a_slot_written: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_UPD |=> slot_valid_ff[$past(wr_idx)])
      else $error("written slot not marked valid");

   // a result only appears from the output state
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(state_ff) == S_OUT)
      else $error("result raised outside output state");

   // divider completion only while waiting on it
   a_div_done: assert property (@(posedge clock) disable iff (reset)
      div_done |-> state_ff == S_DWAIT)
      else $error("divider finished while not awaited");
endmodule
`default_nettype wire

// ===== sv/frlm_div.sv =====
// restoring divider, one quotient bit per cycle
`default_nettype none
module frlm_div import frlm_pkg::*; (
   input  wire      clock,
   input  wire      reset,
   input  wire      start,
   input  time_type dividend,
   input  time_type divisor,
   output logic     done,
   output time_type quotient
);
   time_type                rem_ff, rem_in, quo_ff, quo_in, den_ff;
   logic [DivStepWidth-1:0] cnt_ff, cnt_in;
   logic                    busy_ff, busy_in, done_ff, done_in;
   logic [TimeWidth:0]      trial;

   always_comb begin
      trial   = {rem_ff, quo_ff[TimeWidth-1]};
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in  = '0;
         quo_in  = dividend;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (trial >= {1'b0, den_ff}) begin
            rem_in = TimeWidth'(trial - {1'b0, den_ff});
            quo_in = {quo_ff[TimeWidth-2:0], 1'b1};
         end else begin
            rem_in = trial[TimeWidth-1:0];
            quo_in = {quo_ff[TimeWidth-2:0], 1'b0};
         end
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == DivStepWidth'(TimeWidth - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      cnt_ff <= cnt_in;
      if (start) begin
         den_ff <= divisor;
      end
   end

   assign done     = done_ff;
   assign quotient = quo_ff;
endmodule
`default_nettype wire

// ===== sim/tb.sv =====
// testbench for the frame rate and latency monitor: directed table, then random frame traffic
module tb;
   import frlm_pkg::*;

   typedef struct packed {
      logic [FpsWidth-1:0]  fps;
      logic [TimeWidth-1:0] render;
      logic [TimeWidth-1:0] lag;
      logic [LiveWidth-1:0] live;
   } report_type;

   typedef struct {
      logic                 func;
      logic [IdWidth-1:0]   id;
      logic [TimeWidth-1:0] ts;
      bit                   typed;
      report_type           rep;
   } frame_row_type;

   localparam int Slots = DefaultSlots;
   localparam int DrainCycles = 300;
   localparam int StallLimit = 20000;

   logic clock, reset;
   logic req_valid, req_stall, req_func;
   logic [IdWidth-1:0] req_buffer_id;
   logic [TimeWidth-1:0] req_timestamp_us;
   logic rsp_valid, rsp_stall;
   logic [FpsWidth-1:0] rsp_fps_x100;
   logic [TimeWidth-1:0] rsp_render_avg_us, rsp_queue_lag_avg_us;
   logic [LiveWidth-1:0] rsp_live_buffers;
   logic csr_valid, csr_ready;
   logic [31:0] csr_report_interval_us;

   frame_rate_latency_monitor #(.BUFFER_SLOTS(Slots)) uut (.*);

   // predictor state
   bit                   tbl_used [Slots];
   logic [IdWidth-1:0]   tbl_id   [Slots];
   logic [TimeWidth-1:0] tbl_end  [Slots];
   logic [TimeWidth-1:0] last_begin, render_acc, lag_acc, prev_report;
   logic [FrameWidth-1:0] frames_pred;
   logic [31:0] interval_reg;

   report_type pending_reports[$];
   int errors = 0;
   bit quiet = 0;
   int idle_cycles = 0;

   initial begin
      clock = 0;
      forever #4 clock = ~clock;
   end

   task automatic note_error(input string msg);
      $display("mismatch @%0t: %s", $time, msg);
      errors++;
   endtask

   function automatic logic [TimeWidth-1:0] sat_sum(input logic [TimeWidth-1:0] a,
                                                    input logic [TimeWidth-1:0] b);
      logic [TimeWidth:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[TimeWidth] ? TimeMax : s[TimeWidth-1:0];
   endfunction

   function automatic int lookup_buffer(input logic [IdWidth-1:0] id);
      for (int i = 0; i < Slots; i++)
         if (tbl_used[i] && tbl_id[i] == id) return i;
      return -1;
   endfunction

   // returns 1 when the end event produces a report
   function automatic bit predict_frame(input logic f, input logic [IdWidth-1:0] id,
                                        input logic [TimeWidth-1:0] now,
                                        output report_type rep);
      int s;
      logic [TimeWidth-1:0] span, ms;
      longint unsigned fps;
      int live;
      rep = '0;
      s = lookup_buffer(id);
      if (f == FuncBegin) begin
         last_begin = now;
         if (s >= 0) lag_acc = sat_sum(lag_acc, now - tbl_end[s]);
         return 0;
      end
      if (s < 0) begin
         s = -1;
         for (int i = 0; i < Slots && s < 0; i++)
            if (!tbl_used[i]) s = i;
         if (s < 0) begin
            // full table: evict the oldest end time, lowest index on a tie
            s = 0;
            for (int i = 1; i < Slots; i++)
               if (tbl_end[i] < tbl_end[s]) s = i;
         end
         tbl_used[s] = 1;
         tbl_id[s] = id;
      end
      tbl_end[s] = now;
      render_acc = sat_sum(render_acc, now - last_begin);
      if (frames_pred != FrameMax) frames_pred++;
      span = now - prev_report;
      if (span < {16'd0, interval_reg}) return 0;
      ms = span / UsPerMs;
      if (ms == 0) fps = FpsMax;
      else begin
         fps = longint'(frames_pred) * 100000 / longint'(ms);
         if (fps > FpsMax) fps = FpsMax;
      end
      live = 0;
      for (int i = 0; i < Slots; i++) begin
         if (!tbl_used[i]) continue;
         if (TimeWidth'(now - tbl_end[i]) >= {16'd0, interval_reg}) tbl_used[i] = 0;
         else live++;
      end
      if (live > LiveMax) live = LiveMax;
      rep.fps = fps[FpsWidth-1:0];
      rep.render = render_acc / TimeWidth'(frames_pred);
      rep.lag = lag_acc / TimeWidth'(frames_pred);
      rep.live = live[LiveWidth-1:0];
      prev_report = now;
      frames_pred = 0;
      render_acc = 0;
      lag_acc = 0;
      return 1;
   endfunction

   // one frame event transfer, with optional leading idle burst
   task automatic send_frame(input logic f, input logic [IdWidth-1:0] id,
                             input logic [TimeWidth-1:0] ts, input bit typed = 0,
                             input report_type typed_rep = '0);
      report_type rep;
      bit hit;
      if (!quiet && $urandom_range(0, 9) == 0) begin
         req_valid <= 0;
         repeat ($urandom_range(1, 19)) @(negedge clock);
      end
      req_valid <= 1;
      req_func <= f;
      req_buffer_id <= id;
      req_timestamp_us <= ts;
      do @(posedge clock); while (req_stall);
      hit = predict_frame(f, id, ts, rep);
      if (typed) begin
         if (!hit) note_error("typed row expects a report the predictor does not give");
         pending_reports.push_back(typed_rep);
      end else if (hit) pending_reports.push_back(rep);
      @(negedge clock);
   endtask

   // registers only change once the block has drained
   task automatic write_interval(input logic [31:0] v);
      req_valid <= 0;
      while (pending_reports.size() != 0) @(negedge clock);
      repeat (DrainCycles) @(negedge clock);
      csr_valid <= 1;
      csr_report_interval_us <= v;
      do @(posedge clock); while (!csr_ready);
      interval_reg = v;
      @(negedge clock);
      csr_valid <= 0;
   endtask

   // result checker
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_reports.size() == 0) note_error("report with none expected");
         else begin
            report_type e;
            e = pending_reports.pop_front();
            if (rsp_fps_x100 !== e.fps)
               note_error($sformatf("fps_x100 %0d want %0d", rsp_fps_x100, e.fps));
            if (rsp_render_avg_us !== e.render)
               note_error($sformatf("render_avg %0d want %0d", rsp_render_avg_us, e.render));
            if (rsp_queue_lag_avg_us !== e.lag)
               note_error($sformatf("queue_lag %0d want %0d", rsp_queue_lag_avg_us, e.lag));
            if (rsp_live_buffers !== e.live)
               note_error($sformatf("live %0d want %0d", rsp_live_buffers, e.live));
         end
      end
   end

   // receiver stall bursts, none once quiet
   initial begin
      rsp_stall = 0;
      forever begin
         @(negedge clock);
         if (!quiet && $urandom_range(0, 7) == 0) begin
            rsp_stall <= 1;
            repeat ($urandom_range(1, 19)) @(negedge clock);
            rsp_stall <= 0;
         end
      end
   end

   // watchdog on cycles without any transfer
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || (csr_valid && csr_ready))
         idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= StallLimit) begin
         $display("** frame_rate_latency_monitor: FAILED **");
         $finish;
      end
   end

   // random phase: mostly begin/end pairs over a small id pool, plus noise
   task automatic random_traffic(input int pairs, inout logic [TimeWidth-1:0] now);
      logic [IdWidth-1:0] id;
      int step_max;
      step_max = (interval_reg > 32'd400000) ? 1 << 20 : interval_reg / 3;
      for (int n = 0; n < pairs; n++) begin
         id = $urandom_range(0, 23);
         if ($urandom_range(0, 15) == 0) id = $urandom;
         case ($urandom_range(0, 19))
            0: now = TimeWidth'({$urandom, $urandom});   // wild jump, may go backwards
            1: send_frame(1'($urandom_range(0, 1)), $urandom, now);
            default: begin
               now = now + $urandom_range(0, step_max);
               send_frame(FuncBegin, id, now);
               now = now + $urandom_range(0, step_max);
               send_frame(FuncEnd, id, now);
            end
         endcase
         if (n == pairs / 2 && $urandom_range(0, 1) == 0) begin
            // hold off until the pipe is empty
            req_valid <= 0;
            while (pending_reports.size() != 0) @(negedge clock);
            @(negedge clock);
         end
      end
   endtask

   frame_row_type rows [14];
   logic [TimeWidth-1:0] clk_now;

   initial begin
      rows = '{
         '{FuncBegin, 32'h0, 48'd0, 0, '0},
         '{FuncEnd, 32'h0, 48'd1000000, 1, '{32'd100, 48'd1000000, 48'd0, 5'd1}},
         '{FuncBegin, 32'hFFFFFFFF, 48'd1000010, 0, '0},
         '{FuncEnd, 32'hFFFFFFFF, 48'd1000020, 0, '0},
         '{FuncBegin, 32'h0, 48'd1000100, 0, '0},
         '{FuncEnd, 32'h0, 48'd2000020, 0, '0},
         '{FuncBegin, 32'hFFFFFFFF, TimeMax, 0, '0},
         '{FuncEnd, 32'hFFFFFFFF, TimeMax, 0, '0},
         // timestamp going backwards wraps to a huge difference
         '{FuncBegin, 32'd5, 48'd100, 0, '0},
         '{FuncEnd, 32'd5, 48'd100, 0, '0},
         '{FuncBegin, 32'h0, 48'd200, 0, '0},
         '{FuncEnd, 32'hA5A5A5A5, 48'd300, 0, '0},
         '{FuncBegin, 32'h5A5A5A5A, 48'd300, 0, '0},
         '{FuncEnd, 32'h5A5A5A5A, 48'd1000300, 0, '0}
      };
      for (int i = 0; i < Slots; i++) begin
         tbl_used[i] = 0;
         tbl_id[i] = 0;
         tbl_end[i] = 0;
      end
      last_begin = 0; render_acc = 0; lag_acc = 0; prev_report = 0; frames_pred = 0;
      interval_reg = IntervalReset;
      reset = 1;
      req_valid = 0; req_func = 0; req_buffer_id = 0; req_timestamp_us = 0;
      csr_valid = 0; csr_report_interval_us = 0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 0;

      // directed table at the reset interval
      foreach (rows[i])
         send_frame(rows[i].func, rows[i].id, rows[i].ts, rows[i].typed, rows[i].rep);
      clk_now = 48'd1000300;

      write_interval(32'd1000);                 // minimum interval
      random_traffic(150, clk_now);
      write_interval(32'd5000);
      random_traffic(150, clk_now);
      write_interval(32'hFFFFFFFF);             // maximum, reports only after wild jumps
      random_traffic(100, clk_now);
      write_interval($urandom_range(1000, 50000));
      random_traffic(150, clk_now);
      write_interval(32'd1000);
      quiet = 1;                                // no idling from here on
      random_traffic(280, clk_now);

      req_valid <= 0;
      while (pending_reports.size() != 0) @(negedge clock);
      repeat (DrainCycles) @(negedge clock);
      if (errors == 0) $display("** frame_rate_latency_monitor: PASSED **");
      else $display("** frame_rate_latency_monitor: FAILED **");
      $finish;
   end
endmodule

// ===== sim.f =====
sv/frlm_pkg.sv
sv/frlm_div.sv
sv/frame_rate_latency_monitor.sv
sim/tb.sv
